/* sv/deq_pkg.sv */
// ---------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, operation and status codes, transaction and cell control types.
// ---------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_BACK  = 3'd1,
		KIND_POP_FRONT  = 3'd2,
		KIND_POP_BACK   = 3'd3,
		KIND_REVERSE    = 3'd4,
		KIND_FIND       = 3'd5
	} kind_e;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_e;

	typedef struct packed {
		logic [2:0]        kind;
		logic [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] data_out;
		logic              found;
		status_e           status;
		logic [CNT_W-1:0]  count;
	} rsp_t;

	// Common control broadcast to every cell of the chain
	typedef struct packed {
		logic shift_right;  // take the left neighbour's word
		logic shift_left;   // take the right neighbour's word
		logic load_back;    // the tail cell takes the key word
	} cell_ctrl_t;

endpackage

/* sv/deq_cell.sv */
// ---------------------------------------------------------------------------
// Double-ended queue cell
// One storage word of the chain: shifts either way, loads at the tail,
// and compares its word with the search key.
// ---------------------------------------------------------------------------
module deq_cell
	import deq_pkg::*;
(
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic              live,
	input  logic              tail,
	input  logic [DATA_W-1:0] key,
	input  logic [DATA_W-1:0] left_data,
	input  logic [DATA_W-1:0] right_data,
	output logic [DATA_W-1:0] data,
	output logic              hit
);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_right) begin
			data_q <= left_data;
		end else if (ctrl.shift_left) begin
			data_q <= right_data;
		end else if (ctrl.load_back && tail) begin
			data_q <= key;
		end
	end

	assign data = data_q;
	// only stored entries take part in a search
	assign hit  = live && (data_q == key);

endmodule

/* sv/double_ended_queue_unit.sv */
// ---------------------------------------------------------------------------
// Double-ended queue unit
// Bounded deque of data words held in a chain of shifting cells.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. command.kind picks push front, push back, pop front,
//   pop back, reverse or find; command.value is the word to push or seek.
//   Result channel: done is high for exactly one cycle with result valid;
//   the receiver cannot stall it, so the result must be captured then.
// Timing:
//   Each command is executed on the cell chain in the cycle after acceptance,
//   and the result is presented in the cycle after that.
//   busy is high in the execute cycle only, so a new command can be taken in
//   the same cycle as the previous result, but not while one is executing.
//   Find compares every cell with the key at once in the execute cycle.
// Reset:
//   arst_n clears the count, the direction flag and the handshake state; the
//   cells are not cleared, as only stored entries are ever read.
// ---------------------------------------------------------------------------
module double_ended_queue_unit
	import deq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t command,
	output logic done,
	output rsp_t result
);

	logic              busy_q;
	logic              done_q;
	logic [2:0]        kind_q;
	logic [DATA_W-1:0] value_q;
	logic [CNT_W-1:0]  count_q;
	logic              rev_q;
	rsp_t              result_q;

	logic              accept;
	logic              is_push;
	logic              is_pop;
	logic              at_front;
	logic              full;
	logic              empty;
	cell_ctrl_t        ctrl;
	logic [CNT_W-1:0]  count_d;
	logic [CNT_W-1:0]  back_pos;
	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]  hits;
	rsp_t              result_d;

	assign accept = start && !busy_q;

	// Latch the command and hold busy for the execute cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= command.kind;
			value_q <= command.value;
		end
	end

	// Decode: reversal swaps which physical end serves the logical front
	assign is_push  = (kind_q == KIND_PUSH_FRONT) || (kind_q == KIND_PUSH_BACK);
	assign is_pop   = (kind_q == KIND_POP_FRONT) || (kind_q == KIND_POP_BACK);
	assign at_front = is_push ? ((kind_q == KIND_PUSH_FRONT) != rev_q)
	                          : ((kind_q == KIND_POP_FRONT) != rev_q);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	assign ctrl.shift_right = busy_q && is_push && !full && at_front;
	assign ctrl.load_back   = busy_q && is_push && !full && !at_front;
	assign ctrl.shift_left  = busy_q && is_pop && !empty && at_front;

	always_comb begin
		count_d = count_q;
		if (busy_q && is_push && !full) begin
			count_d = count_q + 1'b1;
		end else if (busy_q && is_pop && !empty) begin
			count_d = count_q - 1'b1;
		end
	end

	assign back_pos = count_q - 1'b1;

	// Cell chain: cell zero is the physical front, cell count-1 the back
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = value_q;
		end else begin : g_inner_l
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_inner_r
			assign right_w = cell_data[i+1];
		end

		deq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.live       (CNT_W'(i) < count_q),
			.tail       (CNT_W'(i) == count_q),
			.key        (value_q),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i]),
			.hit        (hits[i])
		);
	end

	// Build the result of the executing command
	always_comb begin
		result_d.data_out = '0;
		result_d.found    = 1'b0;
		result_d.status   = STATUS_OK;
		result_d.count    = count_d;
		if (is_push && full) begin
			result_d.status = STATUS_FULL;
		end else if (is_pop && empty) begin
			result_d.status = STATUS_EMPTY;
		end else if (is_pop) begin
			result_d.data_out = at_front ? cell_data[0] : cell_data[back_pos[IDX_W-1:0]];
		end else if ((kind_q == KIND_FIND) && (|hits)) begin
			result_d.found    = 1'b1;
			result_d.data_out = value_q;
		end
	end

	// Advance count and direction; hold the result for its strobe cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (busy_q) begin
			count_q <= count_d;
			if (kind_q == KIND_REVERSE) begin
				rev_q <= !rev_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			result_q <= result_d;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result strobe overlaps execution");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status == STATUS_FULL) |-> (result_q.count == CNT_W'(DEPTH)))
		else $error("full reported below depth");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status == STATUS_EMPTY) |-> (result_q.count == '0))
		else $error("empty reported with stored entries");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.found) |-> (result_q.status == STATUS_OK && result_q.count != '0))
		else $error("match reported without stored entries");

endmodule
